// ===== rtl/hbs_pkg.sv =====
// Package for the heightmap bilinear sampler.
// Holds state, action and constant definitions; no dependencies.
package hbs_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_HEIGHT = 2'd1,
    ACT_NORMAL = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RD    = 8'b0000_0010,
    ST_CAP   = 8'b0000_0100,
    ST_BLEND = 8'b0000_1000,
    ST_NRM   = 8'b0001_0000,
    ST_SQRT  = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;

  localparam logic [32:0] ONE_Q16  = 33'd65536;
  localparam logic [14:0] NORM_SAT = 15'd16384;
  localparam logic signed [16:0] HALF_CELL = 17'sd128;

endpackage

// ===== rtl/hbs_if.sv =====
// Request and response channel interfaces of the heightmap sampler.
// Depends on nothing.
interface hbs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [14:0] x_coord;
  logic [14:0] z_coord;
  logic signed [15:0] write_height;
  modport source (output valid, action, x_coord, z_coord, write_height, input ready);
  modport sink   (input valid, action, x_coord, z_coord, write_height, output ready);
endinterface

interface hbs_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] height_out;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, height_out, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, height_out, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== rtl/heightmap_bilinear_sampler.sv =====
// Heightmap sampler top level: height store, sequencer, shared multiplier,
// square root and divider. Depends on hbs_pkg and hbs_if.
//
// channel | dir | payload
// req     | in  | action, x_coord, z_coord, write_height
// rsp     | out | height_out, normal_x, normal_y, normal_z
// cfg     | in  | cfg_we, cfg_index, cfg_wdata (width_chunks, length_chunks)
//
// Height query: one memory read and one capture per corner, then blend steps.
// Normal query: three samples, multiply steps, 32 square-root iterations
// and three divides; the serial square root and divider take most of its
// time. One item is in flight at a time.
// Reset is synchronous; the height store is not cleared. A result waits in
// the output register while the next request is taken.
module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int CHUNK_CELLS         = 16,
  parameter int MAX_CHUNKS_PER_AXIS = 8
) (
  input  logic       clk,
  input  logic       rst,
  hbs_req_if.sink    req,
  hbs_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata
);

  localparam int GRID  = CHUNK_CELLS * MAX_CHUNKS_PER_AXIS;
  localparam int DEPTH = GRID * GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID + 1);

  state_t state;
  logic [3:0] width_chunks, length_chunks;
  logic [1:0] act;
  logic [14:0] xr, zr;
  logic [1:0] k, sidx, bstep, nstep, job;
  logic signed [15:0] corner [4];
  logic signed [15:0] samp [3];
  logic signed [27:0] t0;
  logic signed [32:0] ma, mb;
  logic signed [65:0] p;
  logic [32:0] aa;
  logic [63:0] v, res, bitr;
  logic [32:0] rem;
  logic [14:0] nlo, q;
  logic [3:0] cnt;
  logic dload;
  logic signed [15:0] hres, nx, ny, nz;
  logic rvalid;
  logic signed [15:0] o_h, o_nx, o_ny, o_nz;
  logic [15:0] mem [DEPTH];
  logic [15:0] mq;
  logic [AW-1:0] maddr;
  logic mwe;

  // grid size in cells
  function automatic logic [CW-1:0] cells_of(input logic [3:0] r);
    logic [4:0] c;
    c = (r == 4'd0) ? 5'd1 : {1'b0, r};
    if (32'(c) > MAX_CHUNKS_PER_AXIS) c = 5'(MAX_CHUNKS_PER_AXIS);
    return CW'(32'(c) * CHUNK_CELLS);
  endfunction

  logic [CW-1:0] cells_x, cells_z;
  assign cells_x = cells_of(width_chunks);
  assign cells_z = cells_of(length_chunks);

  // sample point of the current sample index
  logic signed [16:0] offx, offz, cx, cz;
  logic [7:0] x0, z0, fx, fz;
  logic [8:0] x1, z1, xsel, zsel;
  logic oob;
  always_comb begin
    offx = '0;
    offz = '0;
    if (act == ACT_NORMAL) begin
      case (sidx)
        2'd1:    begin offx = -HALF_CELL; offz = HALF_CELL; end
        2'd2:    begin offx = HALF_CELL;  offz = -HALF_CELL; end
        default: begin offx = -HALF_CELL; offz = -HALF_CELL; end
      endcase
    end
    cx = $signed({2'b00, xr}) + offx;
    cz = $signed({2'b00, zr}) + offz;
    x0 = cx[15:8];
    z0 = cz[15:8];
    fx = cx[7:0];
    fz = cz[7:0];
    x1 = {1'b0, x0} + {8'd0, fx != 8'd0};
    z1 = {1'b0, z0} + {8'd0, fz != 8'd0};
    oob = cx[16] || cz[16] || (12'(x1) >= 12'(cells_x)) || (12'(z1) >= 12'(cells_z));
    xsel = k[0] ? x1 : {1'b0, x0};
    zsel = k[1] ? z1 : {1'b0, z0};
  end

  // write cell of the incoming request, or the corner read address in ST_RD
  logic wr_in;
  always_comb begin
    wr_in = req.valid && req.ready && (req.action == ACT_WRITE) &&
            (12'(req.x_coord[14:8]) < 12'(cells_x)) &&
            (12'(req.z_coord[14:8]) < 12'(cells_z));
    mwe = wr_in;
    if (state == ST_RD)
      maddr = AW'(32'(zsel) * GRID + 32'(xsel));
    else
      maddr = AW'(32'(req.z_coord[14:8]) * GRID + 32'(req.x_coord[14:8]));
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= req.write_height;
    mq <= mem[maddr];
  end

  // normal terms
  logic signed [16:0] da, db;
  logic [16:0] mag;
  logic [32:0] s;
  logic [39:0] num;
  logic sat;
  logic [33:0] remsh;
  logic [14:0] qf, qs;
  logic signed [15:0] comp;
  always_comb begin
    da = 17'(samp[2]) - 17'(samp[0]);
    db = 17'(samp[1]) - 17'(samp[0]);
    s = res[32:0];
    if (job == 2'd1)      mag = da[16] ? 17'(-da) : 17'(da);
    else                  mag = db[16] ? 17'(-db) : 17'(db);
    if (job == 2'd0) num = (40'd1 << 30) + 40'(res[33:1]);
    else             num = (40'(mag) << 22) + 40'(res[33:1]);
    sat = 33'(num[39:15]) >= s;
    remsh = {rem, nlo[cnt]};
    qf = {q[13:0], remsh >= 34'(s)};
    qs = (qf > NORM_SAT) ? NORM_SAT : qf;
    if (dload) qs = NORM_SAT;
    if ((job == 2'd1 && !da[16] && da != 17'sd0) || (job == 2'd2 && !db[16] && db != 17'sd0))
      comp = -$signed({1'b0, qs});
    else
      comp = $signed({1'b0, qs});
  end

  // shared multiplier operands
  logic signed [27:0] t1;
  logic signed [39:0] r;
  logic signed [39:0] rr;
  always_comb begin
    t1 = (28'(corner[2]) <<< 8) + p[27:0];
    r  = (40'(t0) <<< 8) + p[39:0];
    rr = (r + 40'sd32768) >>> 16;
    ma = '0;
    mb = '0;
    if (state == ST_BLEND) begin
      case (bstep)
        2'd0:    begin ma = 33'(17'(corner[1]) - 17'(corner[0])); mb = 33'({1'b0, fx}); end
        2'd1:    begin ma = 33'(17'(corner[3]) - 17'(corner[2])); mb = 33'({1'b0, fx}); end
        default: begin ma = 33'(t1 - t0); mb = 33'({1'b0, fz}); end
      endcase
    end else if (state == ST_NRM) begin
      case (nstep)
        2'd0:    begin ma = 33'(da); mb = 33'(da); end
        2'd1:    begin ma = 33'(db); mb = 33'(db); end
        default: begin ma = $signed(aa); mb = $signed(p[32:0] + ONE_Q16); end
      endcase
    end
  end

  always_ff @(posedge clk) p <= ma * mb;

  // sample finish
  logic fin;
  logic signed [15:0] sval;
  logic last;
  assign fin  = (state == ST_RD && k == 2'd0 && oob) || (state == ST_BLEND && bstep == 2'd3);
  assign sval = (state == ST_RD) ? 16'sd0 : rr[15:0];
  assign last = (act == ACT_NORMAL) ? (sidx == 2'd2) : 1'b1;

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rvalid        <= 1'b0;
      width_chunks  <= 4'd8;
      length_chunks <= 4'd8;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH[0]) width_chunks <= cfg_wdata;
        else                           length_chunks <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) rvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            act  <= req.action;
            xr   <= req.x_coord;
            zr   <= req.z_coord;
            hres <= '0;
            nx   <= '0;
            ny   <= '0;
            nz   <= '0;
            sidx <= '0;
            k    <= '0;
            if (req.action == ACT_HEIGHT || req.action == ACT_NORMAL) state <= ST_RD;
            else                                                      state <= ST_DONE;
          end
        end
        ST_RD: begin
          if (!(k == 2'd0 && oob)) state <= ST_CAP;
        end
        ST_CAP: begin
          corner[k] <= mq;
          k <= k + 2'd1;
          bstep <= '0;
          state <= (k == 2'd3) ? ST_BLEND : ST_RD;
        end
        ST_BLEND: begin
          bstep <= bstep + 2'd1;
          if (bstep == 2'd1) t0 <= (28'(corner[0]) <<< 8) + p[27:0];
        end
        ST_NRM: begin
          nstep <= nstep + 2'd1;
          if (nstep == 2'd1) aa <= p[32:0] + ONE_Q16;
          if (nstep == 2'd3) begin
            v     <= p[63:0];
            res   <= '0;
            bitr  <= 64'd1 << 62;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (v >= res + bitr) begin
            v   <= v - (res + bitr);
            res <= (res >> 1) + bitr;
          end else begin
            res <= res >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr == 64'd1) begin
            job   <= '0;
            cnt   <= '0;
            dload <= 1'b1;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dload && !sat) begin
            dload <= 1'b0;
            rem   <= 33'(num[39:15]);
            nlo   <= num[14:0];
            q     <= '0;
            cnt   <= 4'd14;
          end else begin
            if (!dload) begin
              rem <= (remsh >= 34'(s)) ? 33'(remsh - 34'(s)) : remsh[32:0];
              q   <= qf;
              cnt <= cnt - 4'd1;
            end
            if (dload || cnt == 4'd0) begin
              case (job)
                2'd0:    ny <= comp;
                2'd1:    nx <= comp;
                default: nz <= comp;
              endcase
              job   <= job + 2'd1;
              dload <= 1'b1;
              if (job == 2'd2) state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!rvalid || rsp.ready) begin
            rvalid <= 1'b1;
            o_h    <= hres;
            o_nx   <= nx;
            o_ny   <= ny;
            o_nz   <= nz;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fin) begin
        samp[sidx] <= sval;
        k <= '0;
        if (last) begin
          if (act == ACT_HEIGHT) begin
            hres  <= sval;
            state <= ST_DONE;
          end else begin
            nstep <= '0;
            state <= ST_NRM;
          end
        end else begin
          sidx  <= sidx + 2'd1;
          state <= ST_RD;
        end
      end
    end
  end

  assign rsp.valid      = rvalid;
  assign rsp.height_out = o_h;
  assign rsp.normal_x   = o_nx;
  assign rsp.normal_y   = o_ny;
  assign rsp.normal_z   = o_nz;

endmodule

// ===== rtl/hbs_check.sv =====
// Port-level checks of the heightmap sampler, bound to the top level.
// Depends on heightmap_bilinear_sampler ports only.
module hbs_check (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic signed [15:0] height_out,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("request taken while busy");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (height_out == 16'sd0) ||
                  (normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0))
    else $error("height and normal both set");

  a_ny_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !normal_y[15]) else $error("negative normal y");

endmodule

bind heightmap_bilinear_sampler hbs_check u_hbs_check (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .height_out (rsp.height_out),
  .normal_x   (rsp.normal_x),
  .normal_y   (rsp.normal_y),
  .normal_z   (rsp.normal_z)
);

// ===== sim/tb.sv =====
// Self-checking testbench for heightmap_bilinear_sampler: checks bilinear
// height and surface normal queries against a local predictor.
// Depends on hbs_pkg, hbs_req_if/hbs_rsp_if and the sampler RTL.
module tb;
  import hbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_CELLS = 128;
  localparam int CHUNK = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic signed [15:0] height;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } sample_result_t;

  class height_scoreboard;
    sample_result_t pending[$];
    int checked;

    function void note(sample_result_t r);
      pending.push_back(r);
    endfunction

    // Empty string on a match, else a one-line description.
    function string check(sample_result_t got);
      sample_result_t e;
      if (pending.size() == 0) return "response with no request outstanding";
      e = pending.pop_front();
      checked++;
      if (got === e) return "";
      return $sformatf("resp #%0d: got h=%0d n=(%0d,%0d,%0d) exp h=%0d n=(%0d,%0d,%0d)",
                       checked, got.height, got.nx, got.ny, got.nz,
                       e.height, e.nx, e.ny, e.nz);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [3:0] cfg_wdata;

  hbs_req_if req ();
  hbs_rsp_if rsp ();

  heightmap_bilinear_sampler dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  height_scoreboard sb = new();
  int hmap[GRID_CELLS*GRID_CELLS];
  bit written[GRID_CELLS*GRID_CELLS];
  logic [3:0] width_reg = 4'd8;
  logic [3:0] length_reg = 4'd8;
  int src_idle, dst_idle;
  int errors, cycles, n_sent, n_writes, n_heights, n_normals;

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic int cells_of(logic [3:0] r);
    int c;
    c = (r == 0) ? 1 : (r > 8) ? 8 : r;
    return c * CHUNK;
  endfunction

  function automatic bit in_grid(int cx, int cz);
    if (cx < 0 || cz < 0) return 0;
    return ((cx + 255) >> 8) < cells_of(width_reg) && ((cz + 255) >> 8) < cells_of(length_reg);
  endfunction

  function automatic int cell_at(int x, int z);
    return hmap[z*GRID_CELLS + x];
  endfunction

  function automatic int sample_height(int cx, int cz);
    int x0, z0, x1, z1, fx, fz, t0, t1;
    longint r;
    if (!in_grid(cx, cz)) return 0;
    x0 = cx >> 8; fx = cx & 255; x1 = x0 + (fx != 0);
    z0 = cz >> 8; fz = cz & 255; z1 = z0 + (fz != 0);
    t0 = cell_at(x0, z0)*256 + (cell_at(x1, z0) - cell_at(x0, z0))*fx;
    t1 = cell_at(x0, z1)*256 + (cell_at(x1, z1) - cell_at(x0, z1))*fx;
    r = longint'(t0)*256 + longint'(t1 - t0)*fz;
    return int'((r + 32768) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int round_div_sat(longint unsigned n, longint unsigned d);
    longint unsigned q;
    q = (n + d/2) / d;
    return (q > 16384) ? 16384 : int'(q);
  endfunction

  function automatic int normal_comp(int d, longint unsigned s);
    int q;
    q = round_div_sat(longint'(d < 0 ? -d : d) << 22, s);
    return (d > 0) ? -q : q;
  endfunction

  // Updates the height map and yields what the block must answer.
  function automatic sample_result_t predict(action_t act, int x, int z, int hw);
    sample_result_t r;
    int h00, h01, h10, a, b;
    longint unsigned s;
    r = '0;
    case (act)
      ACT_WRITE: begin
        if ((x >> 8) < cells_of(width_reg) && (z >> 8) < cells_of(length_reg)) begin
          hmap[(z >> 8)*GRID_CELLS + (x >> 8)] = int'($signed(hw[15:0]));
          written[(z >> 8)*GRID_CELLS + (x >> 8)] = 1'b1;
        end
      end
      ACT_HEIGHT: r.height = 16'(sample_height(x, z));
      ACT_NORMAL: begin
        h00 = sample_height(x - 128, z - 128);
        h01 = sample_height(x - 128, z + 128);
        h10 = sample_height(x + 128, z - 128);
        a = h10 - h00;
        b = h01 - h00;
        s = int_sqrt((longint'(a)*a + 65536) * (longint'(b)*b + 65536));
        r.ny = 16'(round_div_sat(64'd1 << 30, s));
        r.nx = 16'(normal_comp(a, s));
        r.nz = 16'(normal_comp(b, s));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Corner cells that a sample point reads, or none when out of bounds.
  function automatic void corners(int cx, int cz, ref int cq[$]);
    int x0, z0, x1, z1;
    if (!in_grid(cx, cz)) return;
    x0 = cx >> 8; x1 = (cx + 255) >> 8;
    z0 = cz >> 8; z1 = (cz + 255) >> 8;
    cq.push_back(z0*GRID_CELLS + x0);
    cq.push_back(z0*GRID_CELLS + x1);
    cq.push_back(z1*GRID_CELLS + x0);
    cq.push_back(z1*GRID_CELLS + x1);
  endfunction

  task automatic send(action_t act, int x, int z, int hw);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle) gap++;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.x_coord <= x[14:0];
    req.z_coord <= z[14:0];
    req.write_height <= hw[15:0];
    do @(posedge clk); while (!req.ready);
    sb.note(predict(act, x, z, hw));
    n_sent++;
    case (act)
      ACT_WRITE: n_writes++;
      ACT_HEIGHT: n_heights++;
      ACT_NORMAL: n_normals++;
      default: ;
    endcase
  endtask

  // Writes any not yet written cell the query would read before the query itself, so the
  // block never reads an unwritten location.
  task automatic issue(action_t act, int x, int z, int hw);
    int cq[$];
    if (act == ACT_HEIGHT) corners(x, z, cq);
    if (act == ACT_NORMAL) begin
      corners(x - 128, z - 128, cq);
      corners(x - 128, z + 128, cq);
      corners(x + 128, z - 128, cq);
    end
    foreach (cq[i])
      if (!written[cq[i]])
        send(ACT_WRITE, (cq[i] % GRID_CELLS) << 8, (cq[i] / GRID_CELLS) << 8,
             $urandom_range(65535));
    send(act, x, z, hw);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(logic [3:0] w, logic [3:0] l);
    wait_drained();
    req.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH[0];
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_LENGTH[0];
    cfg_wdata <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
    length_reg = l;
  endtask

  function automatic int pick_coord(int ncells, int base);
    int v;
    case ($urandom_range(9))
      0: v = $urandom_range(32767);
      1: v = ncells*256 - $urandom_range(600);
      2: v = $urandom_range(3*256);
      default: v = base*256 + $urandom_range(6*256);
    endcase
    return (v < 0) ? 0 : (v > 32767) ? 32767 : v;
  endfunction

  initial begin
    sample_result_t got;
    string msg;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.height_out, rsp.normal_x, rsp.normal_y, rsp.normal_z};
        msg = sb.check(got);
        if (msg != "") report(msg);
      end
      rsp.ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] grid_w[6] = '{4'd8, 4'd1, 4'd0, 4'd3, 4'd15, 4'd8};
    logic [3:0] grid_l[6] = '{4'd8, 4'd1, 4'd15, 4'd5, 4'd0, 4'd2};
    int wc, lc, bx, bz, sel, phase_end;
    action_t act;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= 1'b0;
    cfg_wdata <= '0;
    req.valid <= 1'b0;
    req.action <= ACT_WRITE;
    req.x_coord <= '0;
    req.z_coord <= '0;
    req.write_height <= '0;
    src_idle = 30;
    dst_idle = 52;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, bounds edges, half-cell offsets, spare action.
    set_grid(4'd8, 4'd8);
    issue(ACT_WRITE, 0, 0, 32767);
    issue(ACT_WRITE, 256, 0, -32768);
    issue(ACT_WRITE, 0, 256, 0);
    issue(ACT_WRITE, 256, 256, 1);
    issue(ACT_HEIGHT, 0, 0, 0);
    issue(ACT_HEIGHT, 128, 128, 0);
    issue(ACT_HEIGHT, 255, 1, 0);
    issue(ACT_NORMAL, 128, 128, 0);
    issue(ACT_NORMAL, 0, 0, 0);
    issue(ACT_NORMAL, 384, 128, 0);
    issue(ACT_WRITE, 32767, 32767, -1);
    issue(ACT_WRITE, 127*256, 127*256, 12345);
    issue(ACT_HEIGHT, 127*256, 127*256, 0);
    issue(ACT_HEIGHT, 127*256 + 1, 0, 0);
    issue(ACT_HEIGHT, 32767, 32767, 0);
    issue(ACT_NORMAL, 127*256, 127*256, 0);
    issue(ACT_NONE, 32767, 32767, -1);
    issue(ACT_HEIGHT, 16384, 16384, 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin src_idle = 52; dst_idle = 30; end
      if (ph == 4) begin src_idle = 0; dst_idle = 0; end
      set_grid(grid_w[ph], grid_l[ph]);
      wc = cells_of(grid_w[ph]);
      lc = cells_of(grid_l[ph]);
      bx = $urandom_range(wc - 1);
      bz = $urandom_range(lc - 1);
      phase_end = n_sent + 226;
      while (n_sent < phase_end) begin
        sel = $urandom_range(99);
        act = (sel < 25) ? ACT_WRITE : (sel < 60) ? ACT_HEIGHT :
              (sel < 95) ? ACT_NORMAL : ACT_NONE;
        issue(act, pick_coord(wc, bx), pick_coord(lc, bz), $urandom_range(65535));
      end
    end

    wait_drained();
    $display("Covered %0d requests: %0d writes, %0d height and %0d normal queries",
             n_sent, n_writes, n_heights, n_normals);
    $display("Six grid sizes including zero and oversized chunk counts; %0d responses checked",
             sb.checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
